@@ rtl/staged_tuple_enumerator_top_macros.svh @@
// Assertion macros used by the checker file of the tuple enumerator.
`ifndef STAGED_TUPLE_ENUMERATOR_TOP_MACROS_SVH
`define STAGED_TUPLE_ENUMERATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define STE_ASSERT_IMP(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define STE_ASSERT_NXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ rtl/ste_pkg.sv @@
// Shared constants of the staged tuple enumerator.
`timescale 1ns / 1ps
package ste_pkg;

  localparam int MAX_DIGITS_DEF  = 8;
  localparam int INDEX_WIDTH_DEF = 16;

  localparam int OPCODE_W  = 2;
  localparam int SEL_W     = 3;
  localparam int SIZE_W    = 16;
  localparam int MASK_W    = 8;
  localparam int POS_W     = 3;
  localparam int TERM_W    = 16;
  localparam int STAGE_W   = 20;
  localparam int DCNT_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_START   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_STRATEGY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_EFFORT  = 2'd3;

endpackage

@@ rtl/ste_ram.sv @@
// Small synchronous RAM with write forwarding and per-entry valid bits reading as zero.
`timescale 1ns / 1ps
module ste_ram #(
  parameter int DEPTH = ste_pkg::MAX_DIGITS_DEF,
  parameter int WIDTH = ste_pkg::INDEX_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // A write to the entry being read wins, so a step may read back its own result.
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else if (vld_r[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

endmodule

@@ rtl/staged_tuple_enumerator_top.sv @@
// Staged tuple enumerator: sequencer walking the size and index memories one digit a cycle.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | opcode, digit select, size, failure mask
//   out     | output    | out_valid / out_ready  | one tuple digit or an exhausted word
//   cfg     | input     | cfg_valid / cfg_ready  | register index and data
//
// A load writes the size memory. A start clears the tuple, then sends n digit words or
// an exhausted word. An advance walks the index memory one digit per cycle in each pass
// (scan, clear, stage check, refill), then sends its words; once exhausted it just says so.
// rst_n is synchronous; both memories read as zero after reset through per-entry valid bits.
// A full output register stalls the word sequencer; input is taken only when idle.
`timescale 1ns / 1ps
module staged_tuple_enumerator_top #(
  parameter int MAX_DIGITS  = ste_pkg::MAX_DIGITS_DEF,
  parameter int INDEX_WIDTH = ste_pkg::INDEX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ste_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [ste_pkg::SEL_W-1:0]       in_digit_select,
  input  logic [ste_pkg::SIZE_W-1:0]      in_size_value,
  input  logic                            in_failure_valid,
  input  logic [ste_pkg::MASK_W-1:0]      in_failure_mask,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ste_pkg::POS_W-1:0]       out_digit_position,
  output logic [ste_pkg::TERM_W-1:0]      out_term_value,
  output logic                            out_empty_domain,
  output logic                            out_exhausted,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ste_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ste_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import ste_pkg::*;

  localparam int AW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int NW   = $clog2(MAX_DIGITS + 1);
  localparam int IW   = INDEX_WIDTH;
  localparam int CMPW = (IW + 1 > STAGE_W + 1) ? IW + 1 : STAGE_W + 1;
  localparam int RW   = (IW + NW > STAGE_W + 1) ? IW + NW : STAGE_W + 1;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_START     = 4'd1;
  localparam logic [3:0] ST_MAX_SCAN  = 4'd2;
  localparam logic [3:0] ST_MAX_CHK   = 4'd3;
  localparam logic [3:0] ST_MAX_FIND  = 4'd4;
  localparam logic [3:0] ST_NMAX_FIND = 4'd5;
  localparam logic [3:0] ST_SUM_SCAN  = 4'd6;
  localparam logic [3:0] ST_SUM_FILL  = 4'd7;
  localparam logic [3:0] ST_NSUM      = 4'd8;
  localparam logic [3:0] ST_NEXT      = 4'd9;
  localparam logic [3:0] ST_CLR       = 4'd10;
  localparam logic [3:0] ST_EMIT      = 4'd11;
  localparam logic [3:0] ST_EXH       = 4'd12;

  // Configuration registers.
  logic [DCNT_W-1:0] dcnt_r;
  logic [SIZE_W-1:0] tlim_r;
  logic              sum_r;
  logic              fe_r;

  // Sequencer state.
  logic [3:0]         state_r, state_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [STAGE_W-1:0] stage_r, stage_nxt;
  logic [IW-1:0]      total_r, total_nxt;
  logic [NW-1:0]      prefix_r, prefix_nxt;
  logic               more_r, more_nxt;
  logic [RW-1:0]      rest_r, rest_nxt;
  logic [IW-1:0]      big_r, big_nxt;
  logic               zero_r, zero_nxt;
  logic [3:0]         ret_st_r, ret_st_nxt;
  logic [AW-1:0]      ret_addr_r, ret_addr_nxt;

  // Output register.
  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [TERM_W-1:0] out_idx_r;
  logic              out_emp_r, out_exh_r, out_last_r;
  logic              out_ld;
  logic [POS_W-1:0]  ld_pos;
  logic [TERM_W-1:0] ld_idx;
  logic              ld_emp, ld_exh, ld_last;

  // Memory ports.
  logic              sz_we;
  logic [AW-1:0]     sz_wa;
  logic [IW-1:0]     sz_wd, sz_q;
  logic              ix_we;
  logic [IW-1:0]     ix_wd, ix_q;

  // Working values.
  logic              in_acc;
  logic [NW-1:0]     n;
  logic [AW-1:0]     last_addr;
  logic              at_first;
  logic [NW-1:0]     next_pos;
  logic [IW:0]       nv;
  logic [CMPW-1:0]   stage_c;
  logic [IW-1:0]     mv, take_v;
  logic [RW-1:0]     rest_left;
  logic              slot_free;
  logic [NW-1:0]     mask_pfx, pfx_eff, pfx_clip;
  logic [SIZE_W-1:0] ld_size;
  logic [IW-1:0]     big_c;
  logic              zero_c;
  logic [STAGE_W:0]  goal, acc;
  logic [STAGE_W-1:0] stage_inc;
  logic [IW-1:0]     r1_dummy;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign n         = (int'(dcnt_r) > MAX_DIGITS) ? NW'(MAX_DIGITS) : NW'(dcnt_r);
  assign last_addr = AW'(n - NW'(1));
  assign at_first  = (addr_r == '0);
  assign next_pos  = NW'(addr_r) + NW'(1);
  assign nv        = {1'b0, ix_q} + (IW+1)'(1);
  assign stage_c   = CMPW'(stage_r);
  assign mv        = (sz_q != '0) ? sz_q - IW'(1) : '0;
  assign take_v    = (RW'(mv) > rest_r) ? IW'(rest_r) : mv;
  assign rest_left = rest_r - RW'(take_v);
  assign slot_free = !out_valid_r || out_ready;
  assign big_c     = (sz_q > big_r) ? sz_q : big_r;
  assign zero_c    = zero_r || (sz_q == '0);
  assign goal      = {1'b0, stage_r} + (STAGE_W+1)'(1);
  assign acc       = goal - (STAGE_W+1)'(rest_left);
  assign stage_inc = stage_r + STAGE_W'(1);
  assign r1_dummy  = '0;

  // The prefix after a failure is one past the highest flagged digit in use.
  always_comb begin
    mask_pfx = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (in_failure_mask[i] && (i < int'(n))) begin
        mask_pfx = NW'(i + 1);
      end
    end
  end

  assign pfx_eff  = in_failure_valid ? mask_pfx : prefix_r;
  assign pfx_clip = (pfx_eff < n) ? pfx_eff : n;

  // Size loads, clipped to the term limit.
  assign ld_size = ((tlim_r != '0) && (in_size_value > tlim_r)) ? tlim_r : in_size_value;
  assign sz_we   = in_acc && (in_opcode == OP_LOAD) && (int'(in_digit_select) < MAX_DIGITS);
  assign sz_wa   = AW'(in_digit_select);
  assign sz_wd   = IW'(ld_size);

  ste_ram #(.DEPTH(MAX_DIGITS), .WIDTH(IW)) u_size_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (sz_we),
    .waddr (sz_wa),
    .wdata (sz_wd),
    .raddr (addr_nxt),
    .rdata (sz_q)
  );

  ste_ram #(.DEPTH(MAX_DIGITS), .WIDTH(IW)) u_index_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ix_we),
    .waddr (addr_r),
    .wdata (ix_wd),
    .raddr (addr_nxt),
    .rdata (ix_q)
  );

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    stage_nxt    = stage_r;
    total_nxt    = total_r;
    prefix_nxt   = prefix_r;
    more_nxt     = more_r;
    rest_nxt     = rest_r;
    big_nxt      = big_r;
    zero_nxt     = zero_r;
    ret_st_nxt   = ret_st_r;
    ret_addr_nxt = ret_addr_r;
    ix_we        = 1'b0;
    ix_wd        = r1_dummy;
    out_ld       = 1'b0;
    ld_pos       = '0;
    ld_idx       = '0;
    ld_emp       = 1'b0;
    ld_exh       = 1'b0;
    ld_last      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        addr_nxt = '0;
        if (in_acc) begin
          case (in_opcode)
            OP_START: begin
              stage_nxt  = '0;
              prefix_nxt = n;
              if (n == '0) begin
                total_nxt = IW'(1);
                more_nxt  = 1'b0;
                state_nxt = ST_EXH;
              end else begin
                big_nxt   = '0;
                zero_nxt  = 1'b0;
                addr_nxt  = last_addr;
                state_nxt = ST_START;
              end
            end
            OP_ADVANCE: begin
              if (!more_r) begin
                state_nxt = ST_EXH;
              end else begin
                prefix_nxt = pfx_eff;
                if (sum_r) begin
                  if (n == '0) begin
                    state_nxt = ST_NEXT;
                  end else begin
                    rest_nxt  = '0;
                    addr_nxt  = last_addr;
                    state_nxt = ST_SUM_SCAN;
                  end
                end else if (pfx_clip == '0) begin
                  state_nxt = ST_NEXT;
                end else begin
                  addr_nxt  = AW'(pfx_clip - NW'(1));
                  state_nxt = ST_MAX_SCAN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_START: begin
        ix_we    = 1'b1;
        ix_wd    = '0;
        big_nxt  = big_c;
        zero_nxt = zero_c;
        if (at_first) begin
          total_nxt = (big_c > IW'(1)) ? big_c : IW'(1);
          more_nxt  = fe_r || !zero_c;
          addr_nxt  = '0;
          state_nxt = (fe_r || !zero_c) ? ST_EMIT : ST_EXH;
        end else begin
          addr_nxt = addr_r - AW'(1);
        end
      end

      ST_MAX_SCAN: begin
        if ((nv < {1'b0, sz_q}) && (CMPW'(nv) <= stage_c)) begin
          ix_we = 1'b1;
          ix_wd = nv[IW-1:0];
          // Stages zero and one need no check that the tuple reaches the stage.
          if (stage_r <= STAGE_W'(1)) begin
            ret_st_nxt   = ST_EMIT;
            ret_addr_nxt = '0;
          end else begin
            ret_st_nxt   = ST_MAX_CHK;
            ret_addr_nxt = addr_r;
          end
          if (next_pos >= n) begin
            state_nxt = ret_st_nxt;
            addr_nxt  = ret_addr_nxt;
          end else begin
            state_nxt = ST_CLR;
            addr_nxt  = addr_r + AW'(1);
          end
        end else if (at_first) begin
          state_nxt = ST_NEXT;
        end else begin
          addr_nxt = addr_r - AW'(1);
        end
      end

      ST_MAX_CHK: begin
        if (CMPW'(ix_q) >= stage_c) begin
          addr_nxt  = '0;
          state_nxt = ST_EMIT;
        end else if (at_first) begin
          addr_nxt  = last_addr;
          state_nxt = ST_MAX_FIND;
        end else begin
          addr_nxt = addr_r - AW'(1);
        end
      end

      ST_MAX_FIND: begin
        if (CMPW'(sz_q) > stage_c) begin
          ix_we        = 1'b1;
          ix_wd        = IW'(stage_r);
          ret_st_nxt   = ST_EMIT;
          ret_addr_nxt = '0;
          if (next_pos >= n) begin
            state_nxt = ST_EMIT;
            addr_nxt  = '0;
          end else begin
            state_nxt = ST_CLR;
            addr_nxt  = addr_r + AW'(1);
          end
        end else if (at_first) begin
          state_nxt = ST_NEXT;
        end else begin
          addr_nxt = addr_r - AW'(1);
        end
      end

      ST_NEXT: begin
        prefix_nxt = n;
        if (sum_r) begin
          if (n == '0) begin
            stage_nxt = '0;
            more_nxt  = 1'b0;
            state_nxt = ST_EXH;
          end else begin
            rest_nxt  = RW'(goal);
            addr_nxt  = last_addr;
            state_nxt = ST_NSUM;
          end
        end else begin
          stage_nxt = stage_inc;
          if ((CMPW'(stage_inc) >= CMPW'(total_r)) || (n == '0)) begin
            more_nxt  = 1'b0;
            state_nxt = ST_EXH;
          end else begin
            ret_st_nxt   = ST_NMAX_FIND;
            ret_addr_nxt = last_addr;
            addr_nxt     = '0;
            state_nxt    = ST_CLR;
          end
        end
      end

      ST_NMAX_FIND: begin
        if (CMPW'(sz_q) > stage_c) begin
          ix_we     = 1'b1;
          ix_wd     = IW'(stage_r);
          addr_nxt  = '0;
          state_nxt = ST_EMIT;
        end else if (at_first) begin
          more_nxt  = 1'b0;
          state_nxt = ST_EXH;
        end else begin
          addr_nxt = addr_r - AW'(1);
        end
      end

      ST_SUM_SCAN: begin
        ix_we = 1'b1;
        if ((rest_r != '0) && (nv < {1'b0, sz_q}) && (NW'(addr_r) < prefix_r)) begin
          ix_wd    = nv[IW-1:0];
          rest_nxt = rest_r - RW'(1);
          if (rest_r == RW'(1)) begin
            addr_nxt  = '0;
            state_nxt = ST_EMIT;
          end else begin
            addr_nxt  = last_addr;
            state_nxt = ST_SUM_FILL;
          end
        end else begin
          // Digits passed over give their value back to the remainder.
          ix_wd    = '0;
          rest_nxt = rest_r + RW'(ix_q);
          if (at_first) begin
            state_nxt = ST_NEXT;
          end else begin
            addr_nxt = addr_r - AW'(1);
          end
        end
      end

      ST_SUM_FILL: begin
        ix_we    = 1'b1;
        ix_wd    = take_v;
        rest_nxt = rest_left;
        if ((rest_left == '0) || at_first) begin
          addr_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          addr_nxt = addr_r - AW'(1);
        end
      end

      ST_NSUM: begin
        // Here the remainder holds what the next stage still lacks.
        ix_we    = 1'b1;
        ix_wd    = take_v;
        rest_nxt = rest_left;
        if ((rest_left == '0) || at_first) begin
          stage_nxt = acc[STAGE_W-1:0];
          if (rest_left == '0) begin
            addr_nxt  = '0;
            state_nxt = ST_EMIT;
          end else begin
            more_nxt  = 1'b0;
            state_nxt = ST_EXH;
          end
        end else begin
          addr_nxt = addr_r - AW'(1);
        end
      end

      ST_CLR: begin
        ix_we = 1'b1;
        ix_wd = '0;
        if (next_pos == n) begin
          state_nxt = ret_st_r;
          addr_nxt  = ret_addr_r;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_ld  = 1'b1;
          ld_pos  = POS_W'(addr_r);
          ld_emp  = (sz_q == '0);
          ld_idx  = (sz_q == '0) ? '0 : TERM_W'(ix_q);
          ld_last = (next_pos == n);
          if (next_pos == n) begin
            state_nxt = ST_IDLE;
            addr_nxt  = '0;
          end else begin
            addr_nxt = addr_r + AW'(1);
          end
        end
      end

      ST_EXH: begin
        if (slot_free) begin
          out_ld    = 1'b1;
          ld_exh    = 1'b1;
          ld_last   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      stage_r  <= '0;
      total_r  <= IW'(1);
      prefix_r <= '0;
      more_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      stage_r  <= stage_nxt;
      total_r  <= total_nxt;
      prefix_r <= prefix_nxt;
      more_r   <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    rest_r     <= rest_nxt;
    big_r      <= big_nxt;
    zero_r     <= zero_nxt;
    ret_st_r   <= ret_st_nxt;
    ret_addr_r <= ret_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
      tlim_r <= '0;
      sum_r  <= 1'b0;
      fe_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIGIT_COUNT:  dcnt_r <= cfg_data[DCNT_W-1:0];
        CFG_TERM_LIMIT:   tlim_r <= cfg_data[SIZE_W-1:0];
        CFG_SUM_STRATEGY: sum_r  <= cfg_data[0];
        CFG_FULL_EFFORT:  fe_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_pos_r  <= ld_pos;
      out_idx_r  <= ld_idx;
      out_emp_r  <= ld_emp;
      out_exh_r  <= ld_exh;
      out_last_r <= ld_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit_position = out_pos_r;
  assign out_term_value     = out_idx_r;
  assign out_empty_domain   = out_emp_r;
  assign out_exhausted      = out_exh_r;
  assign out_last           = out_last_r;

endmodule

@@ rtl/ste_checker.sv @@
// Port-level checker of the tuple enumerator and its bind.
`timescale 1ns / 1ps
`include "staged_tuple_enumerator_top_macros.svh"
module ste_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [ste_pkg::OPCODE_W-1:0]  in_opcode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ste_pkg::POS_W-1:0]     out_digit_position,
  input logic [ste_pkg::TERM_W-1:0]    out_term_value,
  input logic                          out_empty_domain,
  input logic                          out_exhausted,
  input logic                          out_last
);
  import ste_pkg::*;

  // An exhausted word is alone and carries nothing else.
  `STE_ASSERT_IMP(a_exh_clean, out_valid && out_exhausted, out_last && out_term_value == '0 && out_digit_position == '0 && !out_empty_domain, "exhausted word not clean")

  // A digit without terms reports index zero.
  `STE_ASSERT_IMP(a_empty_zero, out_valid && out_empty_domain, out_term_value == '0 && !out_exhausted, "empty digit with index")

  // Start and advance always produce words, so the input side closes at once.
  `STE_ASSERT_NXT(a_busy_after_cmd, in_valid && in_ready && (in_opcode == OP_START || in_opcode == OP_ADVANCE), !in_ready, "input taken while busy")

  // A stalled word holds.
  `STE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_term_value) && $stable(out_digit_position) && $stable(out_last), "stalled word changed")

endmodule

bind staged_tuple_enumerator_top ste_checker u_ste_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_opcode          (in_opcode),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_digit_position (out_digit_position),
  .out_term_value     (out_term_value),
  .out_empty_domain   (out_empty_domain),
  .out_exhausted      (out_exhausted),
  .out_last           (out_last)
);
